// ===== rtl/core/sms_pkg.sv =====
// shared types, constants and phase codes of the spi master shifter
package sms_pkg;

   localparam int DIVIDER_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH          = 2;
   localparam int CSR_INDEX_BITS       = 2;
   localparam int CSR_DATA_BITS        = 16;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPI_MODE    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HALF_PERIOD = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CS_GUARD    = 2'd2;

   // sequencer phases
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_LEAD  = 3'd1;
   localparam logic [2:0] PH_SHIFT = 3'd2;
   localparam logic [2:0] PH_WAIT  = 3'd3;
   localparam logic [2:0] PH_TAIL  = 3'd4;

   localparam logic [2:0] BIT_MSB = 3'd7;

   typedef struct packed {
      logic       byte_request;
      logic [7:0] send_byte;
      logic       frame_end;
      logic       miso_level;
   } req_type;

   typedef struct packed {
      logic       sck_level;
      logic       mosi_level;
      logic       select_n;
      logic       ready_res;
      logic       got_valid;
      logic [7:0] got_byte;
   } rsp_type;

   // queue to engine handoff
   typedef struct packed {
      logic    valid;
      req_type item;
   } queue_head_type;

endpackage

// ===== rtl/core/sms_queue.sv =====
// front end: accepts tick transactions into a short fall-through queue
module sms_queue
   import sms_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  req_type        req_item,
   output queue_head_type head,
   input  logic           pop
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

   req_type               entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  push, do_pop;

   assign req_stall  = (count_ff == CNT_FULL);
   assign push       = req_valid && !req_stall;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

// ===== rtl/core/sms_engine.sv =====
// back end: spi phase sequencer, configuration registers and result register
module sms_engine
   import sms_pkg::*;
#(
   parameter int DIVIDER_BITS = DIVIDER_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  queue_head_type            head,
   output logic                      pop,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_item
);

   localparam int LW = (DIVIDER_BITS > CSR_DATA_BITS) ? DIVIDER_BITS : CSR_DATA_BITS;
   localparam logic [LW-1:0] CNT_MAX_W = LW'({DIVIDER_BITS{1'b1}});

   // saturate a register value to the counter range
   function automatic logic [DIVIDER_BITS-1:0] count_limit(input logic [CSR_DATA_BITS-1:0] v);
      logic [LW-1:0] v_w;
      v_w = LW'(v);
      count_limit = DIVIDER_BITS'((v_w > CNT_MAX_W) ? CNT_MAX_W : v_w);
   endfunction

   logic [1:0]                 mode_ff, mode_in;
   logic [CSR_DATA_BITS-1:0]   half_ff, half_in;
   logic [CSR_DATA_BITS-1:0]   guard_ff, guard_in;

   logic [2:0]                 phase_ff, phase_in;
   logic [DIVIDER_BITS-1:0]    count_ff, count_in;
   logic [2:0]                 bit_ff, bit_in;
   logic                       second_ff, second_in;
   logic [7:0]                 out_shift_ff, out_shift_in;
   logic [7:0]                 in_shift_ff, in_shift_in;
   logic                       end_ff, end_in;
   logic                       clk_ff, clk_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_item_ff, rsp_item_in;

   logic                       step;
   logic                       cpol, cpha;
   logic [DIVIDER_BITS-1:0]    hp, gd;
   logic [DIVIDER_BITS:0]      cnt_inc;
   logic                       sample, done, got;

   assign step    = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign pop     = step;
   assign cpol    = mode_ff[1];
   assign cpha    = mode_ff[0];
   assign hp      = count_limit((half_ff == '0) ? CSR_DATA_BITS'(1) : half_ff);
   assign gd      = count_limit(guard_ff);
   assign cnt_inc = {1'b0, count_ff} + 1'b1;

   always_comb begin
      mode_in      = mode_ff;
      half_in      = half_ff;
      guard_in     = guard_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      bit_in       = bit_ff;
      second_in    = second_ff;
      out_shift_in = out_shift_ff;
      in_shift_in  = in_shift_ff;
      end_in       = end_ff;
      clk_in       = clk_ff;
      sample       = 1'b0;
      done         = 1'b0;
      got          = 1'b0;

      if (step) begin
         unique case (phase_ff)
            PH_IDLE, PH_WAIT: begin
               if (head.item.byte_request) begin
                  out_shift_in = head.item.send_byte;
                  in_shift_in  = '0;
                  end_in       = head.item.frame_end;
                  bit_in       = BIT_MSB;
                  second_in    = 1'b0;
                  count_in     = '0;
                  phase_in     = PH_SHIFT;
                  if (phase_ff == PH_IDLE && gd != '0) begin
                     phase_in = PH_LEAD;
                  end
               end
            end
            PH_LEAD, PH_TAIL: begin
               count_in = cnt_inc[DIVIDER_BITS-1:0];
               if (cnt_inc >= {1'b0, gd}) begin
                  count_in = '0;
                  phase_in = (phase_ff == PH_LEAD) ? PH_SHIFT : PH_IDLE;
               end
            end
            PH_SHIFT: begin
               count_in = cnt_inc[DIVIDER_BITS-1:0];
               if (cnt_inc >= {1'b0, hp}) begin
                  count_in = '0;
                  if (!second_ff) begin
                     clk_in    = ~cpol;
                     second_in = 1'b1;
                     sample    = !cpha;
                  end else begin
                     clk_in    = cpol;
                     second_in = 1'b0;
                     sample    = cpha;
                     done      = 1'b1;
                  end
                  if (sample) begin
                     in_shift_in[bit_ff] = in_shift_ff[bit_ff] | head.item.miso_level;
                     got                 = (bit_ff == '0);
                  end
                  if (done) begin
                     if (bit_ff == '0) begin
                        if (end_ff) begin
                           phase_in = (gd == '0) ? PH_IDLE : PH_TAIL;
                        end else begin
                           phase_in = PH_WAIT;
                        end
                     end else begin
                        bit_in = bit_ff - 1'b1;
                     end
                  end
               end
            end
            default: begin
               count_in = '0;
               phase_in = PH_IDLE;
            end
         endcase
      end

      if (csr_write) begin
         unique case (csr_index)
            REG_SPI_MODE: begin
               mode_in = csr_data[1:0];
               if (!second_ff) begin
                  clk_in = csr_data[1];
               end
            end
            REG_HALF_PERIOD: half_in  = csr_data;
            REG_CS_GUARD:    guard_in = csr_data;
            default: ;
         endcase
      end
   end

   // result seen after this tick
   always_comb begin
      rsp_item_in.sck_level  = clk_in;
      rsp_item_in.mosi_level = out_shift_in[bit_in];
      rsp_item_in.select_n   = (phase_in == PH_IDLE);
      rsp_item_in.ready_res  = (phase_in == PH_IDLE) || (phase_in == PH_WAIT);
      rsp_item_in.got_valid  = got;
      rsp_item_in.got_byte   = got ? in_shift_in : '0;
      rsp_valid_in           = step || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= '0;
         half_ff      <= CSR_DATA_BITS'(1);
         guard_ff     <= CSR_DATA_BITS'(1);
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         bit_ff       <= BIT_MSB;
         second_ff    <= 1'b0;
         out_shift_ff <= '0;
         in_shift_ff  <= '0;
         end_ff       <= 1'b0;
         clk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         half_ff      <= half_in;
         guard_ff     <= guard_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         bit_ff       <= bit_in;
         second_ff    <= second_in;
         out_shift_ff <= out_shift_in;
         in_shift_ff  <= in_shift_in;
         end_ff       <= end_in;
         clk_ff       <= clk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== rtl/core/spi_master_shifter.sv =====
// top level of the spi master shifter: tick queue in front of the phase engine
// a tick transaction is first written into the queue, and its result is then registered in the engine's result register
// throughput: one tick transaction per cycle while the result side is not stalled
// the two-entry queue lets ticks keep arriving while a result is stalled
// reset (synchronous, active high): idle phase, sck low, mode 0, half period 1, guard 1
// configuration writes are always taken and are meant for idle periods only
module spi_master_shifter
   import sms_pkg::*;
#(
   parameter int DIVIDER_BITS = DIVIDER_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // tick transactions in
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_item,
   // pin level results out
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_item,
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   queue_head_type head;
   logic           pop;
   logic           csr_write;

   // register port never back-pressures
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // front: buffers tick transactions so the input side does not wait on the result side until the queue is full
   sms_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .head      (head),
      .pop       (pop)
   );

   // back: advances the spi phase machine one tick per popped transaction
   sms_engine #(
      .DIVIDER_BITS (DIVIDER_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
